FILE: src/sto_pkg.sv
// Package: types, constants, font ROM and helpers for the scaled text overlay.
`default_nettype none
package sto_pkg;

	localparam int WIDTH     = 412;
	localparam int MAX_CHARS = 16;
	localparam int LAYERS    = 2;

	localparam int COORD_W = 9;
	localparam int SCALE_W = 4;
	localparam int COLOR_W = 16;
	localparam int CODE_W  = 8;
	localparam int SLOT_W  = 4;
	localparam int CFG_W   = 16;

	localparam int IDX_W   = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int LEN_W   = $clog2(MAX_CHARS + 1);
	localparam int TW_W    = LEN_W + 7;                 // len * 6 * scale
	localparam int QW      = $clog2(6 * MAX_CHARS);     // dx / scale
	localparam int Q_SPLIT = QW / 2;
	localparam int DX_W    = $clog2(WIDTH);
	localparam int DV_W    = (DX_W > QW + 4) ? DX_W : QW + 4;
	localparam int POS_A   = (TW_W > DX_W + 1) ? TW_W : DX_W + 1;
	localparam int POS_W   = ((POS_A > COORD_W) ? POS_A : COORD_W) + 1;
	localparam int TY_W    = 7;                         // ty < 7 * 15
	localparam int NSTG    = 6;                         // lane stages
	localparam int PIPE_DEPTH = 7;                      // items held, incl. output reg

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic [COLOR_W-1:0] RST_BG_COLOR  = 16'd0;
	localparam logic [COLOR_W-1:0] RST_FG_COLOR  = 16'd57343;
	localparam logic [COORD_W-1:0] RST_TOP0      = 9'd170;
	localparam logic [SCALE_W-1:0] RST_SCALE0    = 4'd4;
	localparam logic [COORD_W-1:0] RST_TOP1      = 9'd245;
	localparam logic [SCALE_W-1:0] RST_SCALE1    = 4'd3;

	localparam logic [CODE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CODE_W-1:0] CHAR_NINE = 8'h39;
	localparam logic [CODE_W-1:0] CHAR_A    = 8'h41;
	localparam logic [CODE_W-1:0] CHAR_Z    = 8'h5a;
	localparam logic [CODE_W-1:0] CHAR_DASH = 8'h2d;
	localparam logic [6:0]        DASH_COL  = 7'h08;
	localparam logic [2:0]        GLYPH_COLS = 3'd5;

	typedef enum logic [2:0] {
		REG_BG_COLOR,
		REG_FIRST_COLOR,
		REG_FIRST_TOP,
		REG_FIRST_SCALE,
		REG_SECOND_COLOR,
		REG_SECOND_TOP,
		REG_SECOND_SCALE,
		REG_SECOND_ENABLE
	} reg_idx_t;

	typedef struct packed {
		logic                cmd;
		logic                layer_sel;
		logic [SLOT_W-1:0]   char_slot;
		logic [CODE_W-1:0]   char_code;
		logic                final_char;
		logic [COORD_W-1:0]  pixel_col;
		logic [COORD_W-1:0]  pixel_row;
	} req_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               layout_error;
	} rsp_t;

	// Per-stage tag carried by the top level pipeline; valid bits travel beside it.
	typedef struct packed {
		logic              pix;
		logic              wr_ok;
		logic              layer;
		logic [IDX_W-1:0]  slot;
		logic [CODE_W-1:0] code;
	} tag_t;

	typedef struct packed {
		logic [NSTG:1]     adv;
		logic              len_we;
		logic [LEN_W-1:0]  len_val;
		logic              mem_we;
		logic [IDX_W-1:0]  mem_addr;
		logic [CODE_W-1:0] mem_data;
	} lane_ctl_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [2:0]        gx;
		logic [2:0]        gy;
		logic              hit;
		logic              err;
	} lane_res_t;

	localparam logic [6:0] FONT_DIGITS [10][5] = '{
		'{7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e}, '{7'h00, 7'h42, 7'h7f, 7'h40, 7'h00},
		'{7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, '{7'h21, 7'h41, 7'h45, 7'h4b, 7'h31},
		'{7'h18, 7'h14, 7'h12, 7'h7f, 7'h10}, '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
		'{7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30}, '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
		'{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1e}
	};

	localparam logic [6:0] FONT_CAPS [26][5] = '{
		'{7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e}, '{7'h7f, 7'h49, 7'h49, 7'h49, 7'h36},
		'{7'h3e, 7'h41, 7'h41, 7'h41, 7'h22}, '{7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c},
		'{7'h7f, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h01},
		'{7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a}, '{7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f},
		'{7'h00, 7'h41, 7'h7f, 7'h41, 7'h00}, '{7'h20, 7'h40, 7'h41, 7'h3f, 7'h01},
		'{7'h7f, 7'h08, 7'h14, 7'h22, 7'h41}, '{7'h7f, 7'h40, 7'h40, 7'h40, 7'h40},
		'{7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f}, '{7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f},
		'{7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e}, '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h06},
		'{7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e}, '{7'h7f, 7'h09, 7'h19, 7'h29, 7'h46},
		'{7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, '{7'h01, 7'h01, 7'h7f, 7'h01, 7'h01},
		'{7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f}, '{7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f},
		'{7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f}, '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
		'{7'h07, 7'h08, 7'h70, 7'h08, 7'h07}, '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43}
	};

	// Column of dots for a code; bit 0 is the top row. Unknown codes are blank.
	function automatic logic [6:0] glyph_column(logic [CODE_W-1:0] code, logic [2:0] gx);
		logic [3:0] di;
		logic [4:0] ci;
		logic [6:0] col;
		di  = 4'(code - CHAR_ZERO);
		ci  = 5'(code - CHAR_A);
		col = '0;
		if (gx < GLYPH_COLS) begin
			if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
				col = FONT_DIGITS[di][gx];
			end else if (code >= CHAR_A && code <= CHAR_Z) begin
				col = FONT_CAPS[ci][gx];
			end else if (code == CHAR_DASH) begin
				col = DASH_COL;
			end
		end
		return col;
	endfunction

	// q / 6 by reciprocal: exact for q below 510.
	function automatic logic [QW-1:0] div6(logic [QW-1:0] q);
		logic [QW+7:0] p;
		p = (QW + 8)'(q) * (QW + 8)'(171);
		return QW'(p >> 10);
	endfunction

endpackage
`default_nettype wire

FILE: src/sto_lane.sv
// One text layer: geometry, scale dividers, text store and its read stage.
`default_nettype none
module sto_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sto_pkg::lane_ctl_t            ctl,
	input  logic [sto_pkg::COORD_W-1:0]   col,
	input  logic [sto_pkg::COORD_W-1:0]   row,
	input  logic [sto_pkg::SCALE_W-1:0]   scale,
	input  logic [sto_pkg::COORD_W-1:0]   top,
	output sto_pkg::lane_res_t            res
);
	import sto_pkg::*;

	logic [LEN_W-1:0]  len_q;
	logic [CODE_W-1:0] store_q [MAX_CHARS];

	// s1
	logic [6:0]                 cell_w_c;
	logic [TW_W-1:0]            tw_c;
	logic signed [COORD_W:0]    ty_c;
	logic [TW_W-1:0]            tw_s1;
	logic signed [COORD_W:0]    ty_s1;
	logic [COORD_W-1:0]         col_s1;

	// s2
	logic [6:0]                 sh7_c;
	logic                       zero_c, wide_c, in_c;
	logic signed [POS_W-1:0]    tw_x_c, tx_c, dx_c;
	logic [DX_W-1:0]            dx_s2;
	logic [TY_W-1:0]            ty_s2;
	logic                       hit_s2, err_s2;

	// s3
	logic [DV_W-1:0]            rem_a_c, div_a_c;
	logic [QW-1:0]              qh_c;
	logic [TY_W-1:0]            rty_c, dty_c;
	logic [2:0]                 gy_c;
	logic [DX_W-1:0]            rem_s3;
	logic [QW-1:0]              qh_s3;
	logic [2:0]                 gy_s3;
	logic                       hit_s3, err_s3;

	// s4
	logic [DV_W-1:0]            rem_b_c, div_b_c;
	logic [QW-1:0]              q_c;
	logic [QW-1:0]              q_s4;
	logic [2:0]                 gy_s4;
	logic                       hit_s4, err_s4;

	// s5
	logic [QW-1:0]              idx_c, mod_c;
	logic [2:0]                 gx_c;
	logic [IDX_W-1:0]           idx_s5;
	logic [2:0]                 gx_s5, gy_s5;
	logic                       hit_s5, err_s5;

	// s6
	logic [CODE_W-1:0]          code_s6;
	logic [2:0]                 gx_s6, gy_s6;
	logic                       hit_s6, err_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (ctl.len_we) begin
			len_q <= ctl.len_val;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_we) begin
			store_q[ctl.mem_addr] <= ctl.mem_data;
		end
	end

	// s1: text width and row offset
	always_comb begin
		cell_w_c = 7'(scale) * 7'd6;
		tw_c     = TW_W'(len_q) * TW_W'(cell_w_c);
		ty_c     = $signed({1'b0, row}) - $signed({1'b0, top});
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[1]) begin
			tw_s1  <= tw_c;
			ty_s1  <= ty_c;
			col_s1 <= col;
		end
	end

	// s2: centering and bounds
	always_comb begin
		sh7_c  = 7'(scale) * 7'd7;
		zero_c = (scale == '0);
		wide_c = POS_W'(tw_s1) > POS_W'(WIDTH);
		tw_x_c = POS_W'(tw_s1);
		tx_c   = (POS_W'(WIDTH) - tw_x_c) >>> 1;
		dx_c   = POS_W'(col_s1) - tx_c;
		in_c   = !ty_s1[COORD_W] && (ty_s1[COORD_W-1:0] < COORD_W'(sh7_c))
		         && !dx_c[POS_W-1] && (dx_c < tw_x_c);
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[2]) begin
			dx_s2  <= DX_W'(dx_c);
			ty_s2  <= TY_W'(ty_s1);
			hit_s2 <= in_c && !zero_c && !wide_c;
			err_s2 <= zero_c || wide_c;
		end
	end

	// s3: upper quotient bits of dx/scale, full ty/scale
	always_comb begin
		rem_a_c = DV_W'(dx_s2);
		qh_c    = '0;
		div_a_c = '0;
		for (int i = QW - 1; i >= Q_SPLIT; i--) begin
			div_a_c = DV_W'(scale) << i;
			if (rem_a_c >= div_a_c) begin
				rem_a_c = rem_a_c - div_a_c;
				qh_c[i] = 1'b1;
			end
		end
		rty_c = ty_s2;
		gy_c  = '0;
		dty_c = '0;
		for (int j = 2; j >= 0; j--) begin
			dty_c = TY_W'(scale) << j;
			if (rty_c >= dty_c) begin
				rty_c   = rty_c - dty_c;
				gy_c[j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[3]) begin
			rem_s3 <= DX_W'(rem_a_c);
			qh_s3  <= qh_c;
			gy_s3  <= gy_c;
			hit_s3 <= hit_s2;
			err_s3 <= err_s2;
		end
	end

	// s4: lower quotient bits
	always_comb begin
		rem_b_c = DV_W'(rem_s3);
		q_c     = qh_s3;
		div_b_c = '0;
		for (int i = Q_SPLIT - 1; i >= 0; i--) begin
			div_b_c = DV_W'(scale) << i;
			if (rem_b_c >= div_b_c) begin
				rem_b_c = rem_b_c - div_b_c;
				q_c[i]  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[4]) begin
			q_s4   <= q_c;
			gy_s4  <= gy_s3;
			hit_s4 <= hit_s3;
			err_s4 <= err_s3;
		end
	end

	// s5: cell index and glyph column; column 5 is the gap
	always_comb begin
		idx_c = div6(q_s4);
		mod_c = q_s4 - idx_c * QW'(6);
		gx_c  = 3'(mod_c);
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[5]) begin
			idx_s5 <= IDX_W'(idx_c);
			gx_s5  <= gx_c;
			gy_s5  <= gy_s4;
			hit_s5 <= hit_s4 && (gx_c != GLYPH_COLS);
			err_s5 <= err_s4;
		end
	end

	// s6: registered store read
	always_ff @(posedge clk) begin
		if (ctl.adv[6]) begin
			code_s6 <= store_q[idx_s5];
			gx_s6   <= gx_s5;
			gy_s6   <= gy_s5;
			hit_s6  <= hit_s5;
			err_s6  <= err_s5;
		end
	end

	assign res = '{code: code_s6, gx: gx_s6, gy: gy_s6, hit: hit_s6, err: err_s6};

endmodule
`default_nettype wire

FILE: src/scaled_text_overlay_pixel_core.sv
// Top level: scaled 5x7 text overlay, one pixel color per request beat.
// Pixel beats go through lane stages s1 to s6 and the output register on to rsp.
// Throughput: one beat per cycle unless rsp stalls; char write beats share the pipe, no rsp.
// A stall on rsp backs up stage by stage; bubbles are squeezed out, nothing is lost.
// Reset clears stage valids, text lengths and config registers to their defaults;
// the text store holds no reset and is undefined until written.
`default_nettype none
module scaled_text_overlay_pixel_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [sto_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  sto_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output sto_pkg::rsp_t                 rsp
);
	import sto_pkg::*;

	// Configuration registers
	logic [COLOR_W-1:0] bg_q;
	logic [COLOR_W-1:0] color_q [2];
	logic [COORD_W-1:0] top_q   [2];
	logic [SCALE_W-1:0] scale_q [2];
	logic               sec_en_q;

	// Pipeline control: adv[k] means stage k loads this cycle
	logic [7:1]  adv;
	tag_t        tag_c, tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic        vld_s6;
	logic        rsp_vld_s7;
	rsp_t        rsp_s7;
	logic        accept;
	logic        slot_ok, layer_ok;

	lane_ctl_t   ctl_c [2];
	lane_res_t   res_c [2];

	logic        draw1;
	logic [6:0]  col0_c, col1_c;
	logic        lit0_c, lit1_c;
	rsp_t        rsp_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q       <= RST_BG_COLOR;
			color_q[0] <= RST_FG_COLOR;
			top_q[0]   <= RST_TOP0;
			scale_q[0] <= RST_SCALE0;
			color_q[1] <= RST_FG_COLOR;
			top_q[1]   <= RST_TOP1;
			scale_q[1] <= RST_SCALE1;
			sec_en_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BG_COLOR:      bg_q       <= cfg_data;
				REG_FIRST_COLOR:   color_q[0] <= cfg_data;
				REG_FIRST_TOP:     top_q[0]   <= cfg_data[COORD_W-1:0];
				REG_FIRST_SCALE:   scale_q[0] <= cfg_data[SCALE_W-1:0];
				REG_SECOND_COLOR:  color_q[1] <= cfg_data;
				REG_SECOND_TOP:    top_q[1]   <= cfg_data[COORD_W-1:0];
				REG_SECOND_SCALE:  scale_q[1] <= cfg_data[SCALE_W-1:0];
				REG_SECOND_ENABLE: sec_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Ready chain: a stage loads when it is empty or its contents move on.
	// With the output register empty every stage can move, so req_ready is high.
	always_comb begin
		adv[7] = !rsp_vld_s7 || rsp_ready;
		adv[6] = !vld_s6 || adv[7];
		adv[5] = !vld_s5 || adv[6];
		adv[4] = !vld_s4 || adv[5];
		adv[3] = !vld_s3 || adv[4];
		adv[2] = !vld_s2 || adv[3];
		adv[1] = !vld_s1 || adv[2];
	end

	assign req_ready = adv[1];
	assign accept    = req_valid && req_ready;

	// Writes past the text size or to a missing layer are dropped, final flag too
	assign slot_ok  = int'(req.char_slot) < MAX_CHARS;
	assign layer_ok = (LAYERS > 1) || (req.layer_sel == 1'b0);

	always_comb begin
		tag_c.pix   = (req.cmd == CMD_PIXEL);
		tag_c.wr_ok = slot_ok && layer_ok;
		tag_c.layer = req.layer_sel;
		tag_c.slot  = IDX_W'(req.char_slot);
		tag_c.code  = req.char_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			vld_s6     <= 1'b0;
			rsp_vld_s7 <= 1'b0;
		end else begin
			if (adv[1]) vld_s1 <= req_valid;
			if (adv[2]) vld_s2 <= vld_s1;
			if (adv[3]) vld_s3 <= vld_s2;
			if (adv[4]) vld_s4 <= vld_s3;
			if (adv[5]) vld_s5 <= vld_s4;
			// write beats retire once they have hit the store
			if (adv[6]) vld_s6     <= vld_s5 && tag_s5.pix;
			if (adv[7]) rsp_vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) tag_s1 <= tag_c;
		if (adv[2]) tag_s2 <= tag_s1;
		if (adv[3]) tag_s3 <= tag_s2;
		if (adv[4]) tag_s4 <= tag_s3;
		if (adv[5]) tag_s5 <= tag_s4;
	end

	// Text length changes at accept, where pixel beats read it; the store is
	// written in stage 5, the same place pixel beats read it, so order holds.
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			ctl_c[k].adv      = adv[NSTG:1];
			ctl_c[k].len_we   = accept && (req.cmd == CMD_WRITE) && slot_ok && layer_ok
			                    && (req.layer_sel == 1'(k)) && req.final_char;
			ctl_c[k].len_val  = LEN_W'(req.char_slot) + LEN_W'(1);
			ctl_c[k].mem_we   = vld_s5 && !tag_s5.pix && tag_s5.wr_ok
			                    && (tag_s5.layer == 1'(k)) && adv[6];
			ctl_c[k].mem_addr = tag_s5.slot;
			ctl_c[k].mem_data = tag_s5.code;
		end
	end

	sto_lane u_lane0 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_c[0]),
		.col    (req.pixel_col),
		.row    (req.pixel_row),
		.scale  (scale_q[0]),
		.top    (top_q[0]),
		.res    (res_c[0])
	);

	sto_lane u_lane1 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_c[1]),
		.col    (req.pixel_col),
		.row    (req.pixel_row),
		.scale  (scale_q[1]),
		.top    (top_q[1]),
		.res    (res_c[1])
	);

	// Font lookup and layering; layer one goes on top when enabled
	always_comb begin
		draw1  = (LAYERS > 1) && sec_en_q;
		col0_c = glyph_column(res_c[0].code, res_c[0].gx);
		col1_c = glyph_column(res_c[1].code, res_c[1].gx);
		lit0_c = res_c[0].hit && col0_c[res_c[0].gy];
		lit1_c = draw1 && res_c[1].hit && col1_c[res_c[1].gy];
		rsp_c.color = bg_q;
		if (lit0_c) begin
			rsp_c.color = color_q[0];
		end
		if (lit1_c) begin
			rsp_c.color = color_q[1];
		end
		rsp_c.layout_error = res_c[0].err || (draw1 && res_c[1].err);
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			rsp_s7 <= rsp_c;
		end
	end

	assign rsp_valid = rsp_vld_s7;
	assign rsp       = rsp_s7;

endmodule
`default_nettype wire

FILE: src/sto_checker.sv
// Port-level checker for the text overlay core, bound to the top level.
`default_nettype none
module sto_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input sto_pkg::req_t  req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input sto_pkg::rsp_t  rsp
);
	import sto_pkg::*;

	logic [3:0] pend_q;
	logic       pix_in, pix_out;

	assign pix_in  = req_valid && req_ready && (req.cmd == CMD_PIXEL);
	assign pix_out = rsp_valid && rsp_ready;

	// pixel beats taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (pix_in && !pix_out) begin
			pend_q <= pend_q + 4'd1;
		end else if (!pix_in && pix_out) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req_ready low with empty output register");

	a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 4'd0)
		else $error("rsp beat without a pending pixel request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'(PIPE_DEPTH))
		else $error("more pixel beats in flight than pipeline stages");

endmodule

bind scaled_text_overlay_pixel_core sto_checker u_sto_checker (.*);
`default_nettype wire

FILE: tb/scaled_text_overlay_pixel_core_tb.sv
// Self-checking testbench for the scaled text overlay pixel core.
module scaled_text_overlay_pixel_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sto_pkg::*;

	localparam int DISP_W       = 412;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;      // pipe is 7 deep; write beats give no rsp
	localparam int PHASE_BEATS  = 150;
	localparam bit [6:0] DASH_DOTS = 7'h08;

	// Font: five dot columns per glyph, column 0 in the top bits, bit 0 = top row.
	// Entries 0..9 are digits, 10..35 are capitals.
	localparam bit [34:0] GLYPHS [36] = '{
		{7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e}, {7'h00, 7'h42, 7'h7f, 7'h40, 7'h00},
		{7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, {7'h21, 7'h41, 7'h45, 7'h4b, 7'h31},
		{7'h18, 7'h14, 7'h12, 7'h7f, 7'h10}, {7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
		{7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30}, {7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
		{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, {7'h06, 7'h49, 7'h49, 7'h29, 7'h1e},
		{7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e}, {7'h7f, 7'h49, 7'h49, 7'h49, 7'h36},
		{7'h3e, 7'h41, 7'h41, 7'h41, 7'h22}, {7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c},
		{7'h7f, 7'h49, 7'h49, 7'h49, 7'h41}, {7'h7f, 7'h09, 7'h09, 7'h09, 7'h01},
		{7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a}, {7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f},
		{7'h00, 7'h41, 7'h7f, 7'h41, 7'h00}, {7'h20, 7'h40, 7'h41, 7'h3f, 7'h01},
		{7'h7f, 7'h08, 7'h14, 7'h22, 7'h41}, {7'h7f, 7'h40, 7'h40, 7'h40, 7'h40},
		{7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f}, {7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f},
		{7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e}, {7'h7f, 7'h09, 7'h09, 7'h09, 7'h06},
		{7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e}, {7'h7f, 7'h09, 7'h19, 7'h29, 7'h46},
		{7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, {7'h01, 7'h01, 7'h7f, 7'h01, 7'h01},
		{7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f}, {7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f},
		{7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f}, {7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
		{7'h07, 7'h08, 7'h70, 7'h08, 7'h07}, {7'h61, 7'h51, 7'h49, 7'h45, 7'h43}
	};

	// Shadow of the register file.
	typedef struct packed {
		bit [15:0] bg;
		bit [15:0] color0;
		bit [15:0] color1;
		bit [8:0]  top0;
		bit [8:0]  top1;
		bit [3:0]  scale0;
		bit [3:0]  scale1;
		bit        second_on;
	} overlay_regs_t;

	// One predicted pixel, with its coordinates for the mismatch report.
	typedef struct packed {
		rsp_t       want;
		logic [8:0] col;
		logic [8:0] row;
	} pixel_expect_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cfg_we;
	logic [2:0]    cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic          req_valid;
	logic          req_ready;
	req_t          req;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	rsp_t          rsp;

	// Predictor state: text store, lengths, which slots hold a known character.
	overlay_regs_t regs;
	bit [7:0]      text_mem [2][16];
	int            text_len [2];
	bit [15:0]     written [2];

	pixel_expect_t pending [$];
	int            mismatch_count = 0;
	int            cycle_count = 0;
	int            send_idle_pct = 0;
	int            stall_pct = 0;
	int            hold_req = 0;   // long receiver hold-off, picked up by the receiver
	int            hold_left = 0;

	scaled_text_overlay_pixel_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run-away guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
				pending.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: random stalls at stall_pct, or a long counted hold-off on request.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Checker: every rsp beat against the oldest predicted pixel.
	always @(posedge clk) begin : check_rsp
		pixel_expect_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected rsp beat color=%h layout_error=%b",
					rsp.color, rsp.layout_error));
			end else begin
				e = pending.pop_front();
				if (rsp.color !== e.want.color)
					report_mismatch($sformatf("pixel (%0d,%0d) color exp %h got %h",
						e.col, e.row, e.want.color, rsp.color));
				if (rsp.layout_error !== e.want.layout_error)
					report_mismatch($sformatf("pixel (%0d,%0d) layout_error exp %b got %b",
						e.col, e.row, e.want.layout_error, rsp.layout_error));
			end
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic bit [6:0] font_dots(bit [7:0] code, int gx);
		bit [34:0] g;
		if (gx > 4)
			return '0;
		if (code >= CHAR_ZERO && code <= CHAR_NINE)
			g = GLYPHS[code - CHAR_ZERO];
		else if (code >= CHAR_A && code <= CHAR_Z)
			g = GLYPHS[10 + code - CHAR_A];
		else if (code == CHAR_DASH)
			return DASH_DOTS;
		else
			return '0;
		return g[(4 - gx) * 7 +: 7];
	endfunction

	function automatic int layer_scale(int k);
		return (k == 0) ? int'(regs.scale0) : int'(regs.scale1);
	endfunction

	function automatic int layer_top(int k);
		return (k == 0) ? int'(regs.top0) : int'(regs.top1);
	endfunction

	// Left edge of the centered text line.
	function automatic int text_left(int k);
		return (DISP_W - text_len[k] * 6 * layer_scale(k)) / 2;
	endfunction

	// Returns {layout fault, lit} of layer k at one pixel.
	function automatic bit [1:0] layer_probe(int k, int col, int row);
		int sc, cell_w, text_w, ty, dx, idx, px;
		bit [6:0] dots;
		sc = layer_scale(k);
		if (sc == 0)
			return 2'b10;
		cell_w = 6 * sc;
		text_w = text_len[k] * cell_w;
		if (text_w > DISP_W)
			return 2'b10;
		ty = row - layer_top(k);
		if (ty < 0 || ty >= 7 * sc)
			return 2'b00;
		dx = col - (DISP_W - text_w) / 2;
		if (dx < 0 || dx >= text_w)
			return 2'b00;
		idx = dx / cell_w;
		px  = dx % cell_w;
		if (px >= 5 * sc)   // spacing column between glyphs
			return 2'b00;
		dots = font_dots(text_mem[k][idx], px / sc);
		return {1'b0, dots[ty / sc]};
	endfunction

	// Background first, then layer zero, then layer one on top when enabled.
	function automatic rsp_t predict_pixel(int col, int row);
		rsp_t     r;
		bit [1:0] p;
		r.color        = regs.bg;
		r.layout_error = 1'b0;
		p = layer_probe(0, col, row);
		r.layout_error = p[1];
		if (p[0])
			r.color = regs.color0;
		if (regs.second_on) begin
			p = layer_probe(1, col, row);
			r.layout_error = r.layout_error | p[1];
			if (p[0])
				r.color = regs.color1;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus

	// Fields a beat does not use are random so every bit toggles.
	function automatic req_t pixel_beat(int col, int row);
		req_t b;
		b.cmd        = CMD_PIXEL;
		b.layer_sel  = 1'($urandom);
		b.char_slot  = 4'($urandom);
		b.char_code  = 8'($urandom);
		b.final_char = 1'($urandom);
		b.pixel_col  = 9'(col);
		b.pixel_row  = 9'(row);
		return b;
	endfunction

	function automatic req_t char_beat(int layer, int slot, bit [7:0] code, bit fin);
		req_t b;
		b.cmd        = CMD_WRITE;
		b.layer_sel  = 1'(layer);
		b.char_slot  = 4'(slot);
		b.char_code  = code;
		b.final_char = fin;
		b.pixel_col  = 9'($urandom);
		b.pixel_row  = 9'($urandom);
		return b;
	endfunction

	// A quarter writes, the rest pixels, most of them aimed at a text line.
	// A length is only set when every slot below it holds a known character.
	function automatic req_t random_beat();
		int        k, sc, len, n, s;
		bit [7:0]  code;
		bit [15:0] mask, covered;
		if ($urandom_range(3) == 0) begin
			k = $urandom_range(1);
			s = ($urandom_range(1) == 0) ? $urandom_range(5) : $urandom_range(15);
			n = $urandom_range(36);
			if ($urandom_range(4) == 0)
				code = 8'($urandom_range(255));
			else if (n < 10)
				code = 8'(CHAR_ZERO + n);
			else if (n < 36)
				code = 8'(CHAR_A + n - 10);
			else
				code = CHAR_DASH;
			mask    = 16'((17'(1) << (s + 1)) - 1);
			covered = written[k] | (16'(1) << s);
			return char_beat(k, s, code, ($urandom_range(2) == 0) && ((covered & mask) == mask));
		end
		k   = $urandom_range(1);
		sc  = layer_scale(k);
		len = text_len[k];
		if ($urandom_range(9) < 7 && sc > 0 && len > 0)
			return pixel_beat(text_left(k) + int'($urandom_range(len * 6 * sc + 1)) - 1,
				layer_top(k) + int'($urandom_range(7 * sc + 1)) - 1);
		if ($urandom_range(9) == 0)
			return pixel_beat($urandom_range(511), $urandom_range(511));
		return pixel_beat($urandom_range(411), $urandom_range(411));
	endfunction

	function automatic overlay_regs_t pick_regs(int kind);
		overlay_regs_t r;
		int            n;
		r.bg        = 16'($urandom);
		r.color0    = 16'($urandom);
		r.color1    = 16'($urandom);
		r.top0      = 9'($urandom_range(411));
		r.top1      = 9'($urandom_range(411));
		n = $urandom_range(9);
		r.scale0    = (n < 7) ? 4'($urandom_range(4, 1)) :
			(n < 9) ? 4'($urandom_range(8, 5)) : 4'($urandom_range(15));
		n = $urandom_range(9);
		r.scale1    = (n < 7) ? 4'($urandom_range(4, 1)) :
			(n < 9) ? 4'($urandom_range(8, 5)) : 4'($urandom_range(15));
		r.second_on = 1'($urandom);
		case (kind)
			0: r = '{bg: 16'h0000, color0: 16'hffff, color1: 16'hffff, top0: 9'd0,
				top1: 9'd0, scale0: 4'd1, scale1: 4'd1, second_on: 1'b1};
			1: r = '{bg: 16'hffff, color0: 16'h0000, color1: 16'h8001, top0: 9'd411,
				top1: 9'd411, scale0: 4'd8, scale1: 4'd8, second_on: 1'b1};
			2: begin
				// zero scale and the widest scale the register holds
				r.scale0    = 4'd0;
				r.scale1    = 4'd15;
				r.second_on = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Sender: optional idle gap, then hold valid until the beat is taken.
	// The predictor is updated at the edge where the beat is accepted.
	task automatic send_beat(input req_t b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= b;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		if (b.cmd == CMD_WRITE) begin
			text_mem[b.layer_sel][b.char_slot] = b.char_code;
			written[b.layer_sel][b.char_slot]  = 1'b1;
			if (b.final_char)
				text_len[b.layer_sel] = int'(b.char_slot) + 1;
		end else begin
			pending.push_back('{want: predict_pixel(b.pixel_col, b.pixel_row),
				col: b.pixel_col, row: b.pixel_row});
		end
	endtask

	// Wait for every predicted pixel, then let trailing write beats leave the pipe.
	task automatic drain();
		req_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Writes the whole register file back to back; only called with the pipe empty.
	task automatic write_regs(input overlay_regs_t r);
		put_reg(REG_BG_COLOR, r.bg);
		put_reg(REG_FIRST_COLOR, r.color0);
		put_reg(REG_FIRST_TOP, CFG_W'(r.top0));
		put_reg(REG_FIRST_SCALE, CFG_W'(r.scale0));
		put_reg(REG_SECOND_COLOR, r.color1);
		put_reg(REG_SECOND_TOP, CFG_W'(r.top1));
		put_reg(REG_SECOND_SCALE, CFG_W'(r.scale1));
		put_reg(REG_SECOND_ENABLE, CFG_W'(r.second_on));
		cfg_we <= 1'b0;
		regs = r;
	endtask

	// ---------------------------------------------------------------- tests

	// Reset defaults with no text: background everywhere, no fault, even off-screen.
	task automatic test_empty_text();
		send_beat(pixel_beat(0, 0));
		send_beat(pixel_beat(206, 172));
		send_beat(pixel_beat(511, 511));
		drain();
	endtask

	// Digit, capital, dash and two blank codes; dots through the middle row,
	// one spacing column, and a pixel of the still disabled second layer.
	task automatic test_glyphs();
		int sc;
		send_beat(char_beat(0, 0, CHAR_ZERO, 1'b0));
		send_beat(char_beat(0, 1, CHAR_Z, 1'b0));
		send_beat(char_beat(0, 2, CHAR_DASH, 1'b0));
		send_beat(char_beat(0, 3, 8'h00, 1'b0));
		send_beat(char_beat(0, 4, 8'hff, 1'b1));
		send_beat(char_beat(1, 0, CHAR_NINE, 1'b0));
		send_beat(char_beat(1, 1, CHAR_A, 1'b1));
		send_beat(char_beat(1, 15, "W", 1'b0));
		sc = layer_scale(0);
		for (int i = 0; i < 5; i++)
			send_beat(pixel_beat(text_left(0) + i * 6 * sc + 2 * sc, layer_top(0) + 3 * sc));
		send_beat(pixel_beat(text_left(0) + 5 * sc, layer_top(0) + 3 * sc));
		send_beat(pixel_beat(text_left(1), layer_top(1) + layer_scale(1)));
		drain();
	endtask

	// Overlapping layers, a too-wide layer, zero scale, scale above eight,
	// and a disabled second layer that must not raise a fault.
	task automatic test_layers_and_errors();
		write_regs('{bg: 16'h1234, color0: 16'hf800, color1: 16'h07e0, top0: 9'd100,
			top1: 9'd100, scale0: 4'd2, scale1: 4'd2, second_on: 1'b1});
		send_beat(pixel_beat(text_left(1), 102));   // second layer wins
		send_beat(pixel_beat(text_left(0), 102));   // first layer only
		drain();
		write_regs('{bg: 16'h1234, color0: 16'hf800, color1: 16'h07e0, top0: 9'd100,
			top1: 9'd100, scale0: 4'd15, scale1: 4'd0, second_on: 1'b1});
		send_beat(pixel_beat(0, 0));
		send_beat(pixel_beat(206, 120));
		drain();
		write_regs('{bg: 16'h1234, color0: 16'hf800, color1: 16'h07e0, top0: 9'd100,
			top1: 9'd100, scale0: 4'd12, scale1: 4'd0, second_on: 1'b0});
		send_beat(pixel_beat(text_left(0) + 24, 136));
		send_beat(pixel_beat(0, 0));
		drain();
	endtask

	// Random beats over several register settings, cycling through idle modes:
	// none, sender idle 70%, receiver stalled 70%, both at 7%.
	task automatic test_random_phases();
		for (int p = 0; p < 10; p++) begin
			write_regs(pick_regs(p));
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 70; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 70; end
				default: begin send_idle_pct = 7; stall_pct = 7; end
			endcase
			repeat (PHASE_BEATS) send_beat(random_beat());
			drain();
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the pipe fills and req_ready must drop until the hold is released.
	task automatic test_backpressure();
		write_regs(pick_regs(3));
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 300;
		repeat (60) send_beat(random_beat());
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		req_valid = 1'b0;
		req       = '0;
		// predictor starts from the reset register values, empty text
		regs = '{bg: RST_BG_COLOR, color0: RST_FG_COLOR, color1: RST_FG_COLOR,
			top0: RST_TOP0, top1: RST_TOP1, scale0: RST_SCALE0, scale1: RST_SCALE1,
			second_on: 1'b0};
		text_len   = '{0, 0};
		written[0] = '0;
		written[1] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_text();
		test_glyphs();
		test_layers_and_errors();
		test_random_phases();
		test_backpressure();
		drain();

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
src/sto_pkg.sv
src/sto_lane.sv
src/scaled_text_overlay_pixel_core.sv
src/sto_checker.sv
tb/scaled_text_overlay_pixel_core_tb.sv
